// ===== rtl/button_click_long_press_detector_core_assert.svh =====
// ----------------------------------------------------------------------------
// button click / long press detector assertion macros
// concurrent checks on a clock with an active-low reset, empty in synthesis
// ----------------------------------------------------------------------------
`ifndef BUTTON_CLICK_LONG_PRESS_DETECTOR_CORE_ASSERT_SVH
`define BUTTON_CLICK_LONG_PRESS_DETECTOR_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define BCLP_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);
// expression must never be true outside reset
`define BCLP_ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error(msg);
`else
`define BCLP_ASSERT(lbl, clk, rst_n, prop, msg)
`define BCLP_ASSERT_NEVER(lbl, clk, rst_n, expr, msg)
`endif
`endif

// ===== rtl/bclp_pkg.sv =====
// ----------------------------------------------------------------------------
// bclp_pkg
// shared types, widths and register map of the button click detector
// ----------------------------------------------------------------------------
package bclp_pkg;

    localparam int TIMER_WIDTH_DEF = 16;
    localparam int CLICK_WIDTH_DEF = 4;

    localparam int LIMIT_W   = 16;
    localparam int COUNT_W   = 4;
    localparam int PHASE_W   = 3;
    localparam int APB_DW    = 32;
    localparam int APB_AW    = 4;
    localparam int CFG_IDX_W = 2;

    localparam logic [LIMIT_W-1:0] SHORT_LIMIT_RST = 16'd200;
    localparam logic [LIMIT_W-1:0] LONG_LIMIT_RST  = 16'd2000;

    typedef enum logic [PHASE_W-1:0] {
        PH_IDLE        = 3'd0,
        PH_PRESSED     = 3'd1,
        PH_AFTER_CLICK = 3'd2,
        PH_AFTER_LONG  = 3'd3,
        PH_WAIT_CLEAR  = 3'd4
    } t_phase;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SHORT_LIMIT = 2'd0,
        CFG_LONG_LIMIT  = 2'd1,
        CFG_ACTIVE_LOW  = 2'd2,
        CFG_CONNECTED   = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [LIMIT_W-1:0] short_limit;
        logic [LIMIT_W-1:0] long_limit;
        logic               active_low;
        logic               connected;
    } t_cfg;

    typedef struct packed {
        logic [COUNT_W-1:0] click_count;
        logic               long_pressed;
        logic               is_pressed;
        logic [PHASE_W-1:0] phase;
    } t_result;

endpackage

// ===== rtl/bclp_ifs.sv =====
// ----------------------------------------------------------------------------
// bclp channel interfaces
// valid/ready channels for tick items and result items
// ----------------------------------------------------------------------------
interface bclp_in_if ();
    logic valid;
    logic ready;
    logic pin_level;
    logic acknowledge;
    logic restart;

    modport source (output valid, output pin_level, output acknowledge, output restart,
                    input ready);
    modport sink (input valid, input pin_level, input acknowledge, input restart,
                  output ready);
endinterface

interface bclp_out_if import bclp_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [COUNT_W-1:0] click_count;
    logic               long_pressed;
    logic               is_pressed;
    logic [PHASE_W-1:0] phase;

    modport source (output valid, output click_count, output long_pressed,
                    output is_pressed, output phase, input ready);
    modport sink (input valid, input click_count, input long_pressed,
                  input is_pressed, input phase, output ready);
endinterface

// ===== rtl/bclp_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// bclp_cfg_regs
// apb register file for limits, polarity and connection
// ----------------------------------------------------------------------------
module bclp_cfg_regs import bclp_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    logic [LIMIT_W-1:0] r_short_limit;
    logic [LIMIT_W-1:0] r_long_limit;
    logic               r_active_low;
    logic               r_connected;
    logic               w_wr;
    t_cfg_idx           w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign w_idx  = t_cfg_idx'(paddr[APB_AW-1:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_short_limit <= SHORT_LIMIT_RST;
            r_long_limit  <= LONG_LIMIT_RST;
            r_active_low  <= 1'b1;
            r_connected   <= 1'b1;
        end else if (w_wr) begin
            unique case (w_idx)
                CFG_SHORT_LIMIT: r_short_limit <= pwdata[LIMIT_W-1:0];
                CFG_LONG_LIMIT:  r_long_limit  <= pwdata[LIMIT_W-1:0];
                CFG_ACTIVE_LOW:  r_active_low  <= pwdata[0];
                CFG_CONNECTED:   r_connected   <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (w_idx)
            CFG_SHORT_LIMIT: prdata = APB_DW'(r_short_limit);
            CFG_LONG_LIMIT:  prdata = APB_DW'(r_long_limit);
            CFG_ACTIVE_LOW:  prdata = APB_DW'(r_active_low);
            CFG_CONNECTED:   prdata = APB_DW'(r_connected);
            default:         prdata = '0;
        endcase
    end

    assign o_cfg.short_limit = r_short_limit;
    assign o_cfg.long_limit  = r_long_limit;
    assign o_cfg.active_low  = r_active_low;
    assign o_cfg.connected   = r_connected;

endmodule

// ===== rtl/bclp_fsm.sv =====
// ----------------------------------------------------------------------------
// bclp_fsm
// phase machine, tick timer and click counters, one step per tick
// ----------------------------------------------------------------------------
`include "button_click_long_press_detector_core_assert.svh"

module bclp_fsm import bclp_pkg::*; #(
    parameter int TIMER_WIDTH = TIMER_WIDTH_DEF,
    parameter int CLICK_WIDTH = CLICK_WIDTH_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_step,
    input  logic    i_pin_level,
    input  logic    i_acknowledge,
    input  logic    i_restart,
    input  t_cfg    i_cfg,
    output t_result o_result
);

    localparam int CMP_W = (TIMER_WIDTH > LIMIT_W) ? TIMER_WIDTH : LIMIT_W;
    localparam int CNT_X = (CLICK_WIDTH > COUNT_W) ? CLICK_WIDTH : COUNT_W;

    t_phase                 r_phase;
    t_phase                 n_phase;
    logic [TIMER_WIDTH-1:0] r_elapsed;
    logic [TIMER_WIDTH-1:0] n_elapsed;
    logic [CLICK_WIDTH-1:0] r_running;
    logic [CLICK_WIDTH-1:0] n_running;
    logic [CLICK_WIDTH-1:0] r_latched;
    logic [CLICK_WIDTH-1:0] n_latched;
    logic                   r_long_flag;
    logic                   n_long_flag;

    logic                   w_pressed;
    logic [TIMER_WIDTH-1:0] w_tick;
    logic                   w_past_short;
    logic                   w_past_long;
    logic [CLICK_WIDTH-1:0] w_latched;
    logic                   w_long;
    logic [CNT_X-1:0]       w_latched_x;

    assign w_pressed    = i_cfg.connected & (i_cfg.active_low ? ~i_pin_level : i_pin_level);
    assign w_tick       = (r_elapsed != '1) ? r_elapsed + 1'b1 : r_elapsed;
    assign w_past_short = CMP_W'(w_tick) > CMP_W'(i_cfg.short_limit);
    assign w_past_long  = CMP_W'(w_tick) > CMP_W'(i_cfg.long_limit);

    // next phase
    always_comb begin
        n_phase = r_phase;
        if (i_restart) begin
            n_phase = PH_WAIT_CLEAR;
        end else begin
            unique case (r_phase)
                PH_IDLE: begin
                    if (w_pressed) n_phase = PH_PRESSED;
                end
                PH_PRESSED: begin
                    if (!w_pressed)       n_phase = PH_AFTER_CLICK;
                    else if (w_past_long) n_phase = PH_AFTER_LONG;
                end
                PH_AFTER_CLICK: begin
                    if (w_pressed)         n_phase = PH_PRESSED;
                    else if (w_past_short) n_phase = PH_IDLE;
                end
                PH_AFTER_LONG: begin
                    if (!w_pressed) n_phase = PH_IDLE;
                end
                default: begin
                    if (!w_pressed) n_phase = PH_IDLE;
                end
            endcase
        end
    end

    // timer, counters and flags that go with each phase step
    always_comb begin
        n_elapsed = w_tick;
        n_running = r_running;
        w_latched = r_latched;
        w_long    = r_long_flag;
        if (!i_restart) begin
            unique case (r_phase)
                PH_IDLE: begin
                    if (w_pressed) begin
                        n_elapsed = '0;
                        n_running = '0;
                    end
                end
                PH_PRESSED: begin
                    if (!w_pressed) begin
                        n_elapsed = '0;
                        if (r_running != '1) n_running = r_running + 1'b1;
                    end else if (w_past_long) begin
                        w_long = 1'b1;
                    end
                end
                PH_AFTER_CLICK: begin
                    if (w_pressed) begin
                        n_elapsed = '0;
                    end else if (w_past_short) begin
                        w_latched = r_running;
                    end
                end
                PH_AFTER_LONG: begin
                    if (!w_pressed) begin
                        n_elapsed = '0;
                        w_long    = 1'b0;
                    end
                end
                default: begin
                    if (!w_pressed) begin
                        n_elapsed = '0;
                        w_latched = '0;
                        w_long    = 1'b0;
                    end
                end
            endcase
        end
        // acknowledge clears after the result is formed
        n_latched   = i_acknowledge ? '0 : w_latched;
        n_long_flag = i_acknowledge ? 1'b0 : w_long;
    end

    assign w_latched_x           = CNT_X'(w_latched);
    assign o_result.click_count  = w_latched_x[COUNT_W-1:0];
    assign o_result.long_pressed = w_long;
    assign o_result.is_pressed   = w_pressed;
    assign o_result.phase        = n_phase;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_WAIT_CLEAR;
            r_elapsed   <= '0;
            r_running   <= '0;
            r_latched   <= '0;
            r_long_flag <= 1'b0;
        end else if (i_step) begin
            r_phase     <= n_phase;
            r_elapsed   <= n_elapsed;
            r_running   <= n_running;
            r_latched   <= n_latched;
            r_long_flag <= n_long_flag;
        end
    end

    `BCLP_ASSERT_NEVER(a_long_phase, i_clk, i_rst_n, r_long_flag && !(r_phase == PH_AFTER_LONG || r_phase == PH_WAIT_CLEAR), "long flag set outside after-long or wait-clear")
    `BCLP_ASSERT(a_restart, i_clk, i_rst_n, i_step && i_restart |=> r_phase == PH_WAIT_CLEAR, "restart did not force wait-clear")
    `BCLP_ASSERT(a_release, i_clk, i_rst_n, i_step && !i_restart && r_phase == PH_PRESSED && !w_pressed |=> r_elapsed == '0 && r_phase == PH_AFTER_CLICK, "release from pressed did not restart timer")
    `BCLP_ASSERT(a_hold, i_clk, i_rst_n, !i_step |=> $stable(r_phase) && $stable(r_elapsed), "state moved without a tick")

endmodule

// ===== rtl/button_click_long_press_detector_core.sv =====
// ----------------------------------------------------------------------------
// button_click_long_press_detector_core
// multi-click and long-press detector stepped by millisecond tick items
// ----------------------------------------------------------------------------
// usage
//   i_tick carries one transaction per millisecond tick: raw pin level,
//   acknowledge and restart. o_result returns exactly one transaction per
//   tick: latched click count, long-press flag, qualified press level and
//   the phase after the update.
//   limits, polarity and connection are set over the apb port while idle.
// pipeline
//   a tick is captured in the input register, stepped through the phase
//   machine and lands in the result register. one tick per cycle is
//   sustained while o_result is not held off; the single combinational
//   step of the phase machine is the only work between the two registers.
// reset
//   phase goes to wait-for-clear, timer and counters clear, limits return
//   to 200 and 2000 ticks, active-low and connected are set.
// stall
//   while o_result is held off the result register keeps its transaction,
//   one more tick waits in the input register, then i_tick.ready drops.
// ----------------------------------------------------------------------------
`include "button_click_long_press_detector_core_assert.svh"

module button_click_long_press_detector_core import bclp_pkg::*; #(
    parameter int TIMER_WIDTH = TIMER_WIDTH_DEF,
    parameter int CLICK_WIDTH = CLICK_WIDTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    bclp_in_if.sink           i_tick,
    bclp_out_if.source        o_result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    t_cfg    w_cfg;
    t_result w_step_res;

    // input register
    logic    r_in_valid;
    logic    r_in_pin;
    logic    r_in_ack;
    logic    r_in_restart;

    // result register
    logic    r_out_valid;
    t_result r_out;

    logic    w_advance;
    logic    w_in_take;

    // step a held tick when the result register is free or being emptied
    assign w_advance    = r_in_valid && (!r_out_valid || o_result.ready);
    assign i_tick.ready = !r_in_valid || w_advance;
    assign w_in_take    = i_tick.valid && i_tick.ready;

    bclp_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    bclp_fsm #(
        .TIMER_WIDTH (TIMER_WIDTH),
        .CLICK_WIDTH (CLICK_WIDTH)
    ) u_fsm (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (w_advance),
        .i_pin_level   (r_in_pin),
        .i_acknowledge (r_in_ack),
        .i_restart     (r_in_restart),
        .i_cfg         (w_cfg),
        .o_result      (w_step_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_tick.ready) begin
            r_in_valid <= i_tick.valid;
        end
    end

    // tick payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in_pin     <= i_tick.pin_level;
            r_in_ack     <= i_tick.acknowledge;
            r_in_restart <= i_tick.restart;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out <= w_step_res;
        end
    end

    assign o_result.valid        = r_out_valid;
    assign o_result.click_count  = r_out.click_count;
    assign o_result.long_pressed = r_out.long_pressed;
    assign o_result.is_pressed   = r_out.is_pressed;
    assign o_result.phase        = r_out.phase;

    `BCLP_ASSERT_NEVER(a_full_ready, i_clk, i_rst_n, r_in_valid && r_out_valid && !o_result.ready && i_tick.ready, "ready high with both registers full and stalled")
    `BCLP_ASSERT(a_step_lands, i_clk, i_rst_n, w_advance |=> r_out_valid, "stepped tick produced no result")
    `BCLP_ASSERT(a_drain, i_clk, i_rst_n, r_out_valid && o_result.ready && !w_advance |=> !r_out_valid, "result repeated after transaction")

endmodule

// ===== dv/button_click_long_press_detector_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_click_long_press_detector_core_tb
// checks the click / long-press detector against its own per-tick predictor:
// directed ticks first, then random gestures under several settings, with
// random source gaps, sink stalls and one long sink hold-off
// ----------------------------------------------------------------------------
module button_click_long_press_detector_core_tb import bclp_pkg::*; ();

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_WAIT  = 10;

    typedef struct packed {
        logic pin;
        logic ack;
        logic restart;
    } t_tick_item;

    logic i_clk;
    logic i_rst_n;

    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    bclp_in_if  tick_if ();
    bclp_out_if res_if ();

    button_click_long_press_detector_core dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tick   (tick_if),
        .o_result (res_if),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // settings as the detector should hold them
    logic [LIMIT_W-1:0] cfg_short_limit;
    logic [LIMIT_W-1:0] cfg_long_limit;
    logic               cfg_active_low;
    logic               cfg_connected;

    // predicted detector state
    t_phase                     det_phase;
    logic [TIMER_WIDTH_DEF-1:0] det_elapsed;
    logic [CLICK_WIDTH_DEF-1:0] det_running;
    logic [CLICK_WIDTH_DEF-1:0] det_latched;
    logic                       det_long;

    t_tick_item tick_queue[$];   // ticks still to be offered
    t_result    due_reports[$];  // predicted per-tick reports, oldest first
    t_tick_item cur_tick;

    int idle_pct;
    int stall_pct;
    int hold_left;
    int errors;
    int ticks_queued;
    int ticks_taken;
    int reports_checked;
    int latched_seen;
    int long_seen;
    int cycles;

    // ------------------------------------------------------------------------
    // clock, reset and known levels on every input from time zero
    // ------------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        i_rst_n             = 1'b0;
        psel                = 1'b0;
        penable             = 1'b0;
        pwrite              = 1'b0;
        paddr               = '0;
        pwdata              = '0;
        tick_if.valid       = 1'b0;
        tick_if.pin_level   = 1'b0;
        tick_if.acknowledge = 1'b0;
        tick_if.restart     = 1'b0;
        res_if.ready        = 1'b0;
        hold_left           = 0;
        idle_pct            = 0;
        stall_pct           = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // ------------------------------------------------------------------------
    // predictor: one tick in, one report out; state advances as the block's
    // ------------------------------------------------------------------------
    function automatic void clear_detector();
        cfg_short_limit = SHORT_LIMIT_RST;
        cfg_long_limit  = LONG_LIMIT_RST;
        cfg_active_low  = 1'b1;
        cfg_connected   = 1'b1;
        det_phase       = PH_WAIT_CLEAR;
        det_elapsed     = '0;
        det_running     = '0;
        det_latched     = '0;
        det_long        = 1'b0;
    endfunction

    function automatic t_result advance_detector(t_tick_item t);
        t_result r;
        logic    pressed;
        pressed = cfg_connected && (cfg_active_low ? !t.pin : t.pin);
        // timer grows first and is compared afterwards, saturating at the top
        if (det_elapsed != '1) det_elapsed = det_elapsed + 1'b1;
        if (t.restart) begin
            det_phase = PH_WAIT_CLEAR;
        end else begin
            case (det_phase)
                PH_IDLE: begin
                    if (pressed) begin
                        det_elapsed = '0;
                        det_running = '0;
                        det_phase   = PH_PRESSED;
                    end
                end
                PH_PRESSED: begin
                    if (!pressed) begin
                        det_elapsed = '0;
                        if (det_running != '1) det_running = det_running + 1'b1;
                        det_phase = PH_AFTER_CLICK;
                    end else if (det_elapsed > cfg_long_limit) begin
                        det_long  = 1'b1;
                        det_phase = PH_AFTER_LONG;
                    end
                end
                PH_AFTER_CLICK: begin
                    if (pressed) begin
                        det_elapsed = '0;
                        det_phase   = PH_PRESSED;
                    end else if (det_elapsed > cfg_short_limit) begin
                        det_latched = det_running;
                        det_phase   = PH_IDLE;
                    end
                end
                PH_AFTER_LONG: begin
                    if (!pressed) begin
                        det_elapsed = '0;
                        det_long    = 1'b0;
                        det_phase   = PH_IDLE;
                    end
                end
                default: begin
                    // wait for clear, and any phase code that should not occur
                    if (!pressed) begin
                        det_elapsed = '0;
                        det_latched = '0;
                        det_long    = 1'b0;
                        det_phase   = PH_IDLE;
                    end
                end
            endcase
        end
        r.click_count  = det_latched[COUNT_W-1:0];
        r.long_pressed = det_long;
        r.is_pressed   = pressed;
        r.phase        = det_phase;
        // acknowledge clears only after the report is formed
        if (t.ack) begin
            det_latched = '0;
            det_long    = 1'b0;
        end
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // tick driver: offers queued ticks, predicts each one as it is taken
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            tick_if.valid <= 1'b0;
        end else begin
            if (tick_if.valid && tick_if.ready) begin
                due_reports.push_back(advance_detector(cur_tick));
                ticks_taken++;
            end
            if (!tick_if.valid || tick_if.ready) begin
                if (tick_queue.size() != 0 && $urandom_range(99) >= idle_pct) begin
                    cur_tick = tick_queue.pop_front();
                    tick_if.valid       <= 1'b1;
                    tick_if.pin_level   <= cur_tick.pin;
                    tick_if.acknowledge <= cur_tick.ack;
                    tick_if.restart     <= cur_tick.restart;
                end else begin
                    tick_if.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // report monitor: random stalls, long hold-off, field-by-field compare
    // ------------------------------------------------------------------------
    task automatic report_mismatch(string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        errors++;
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else begin
            res_if.ready <= (hold_left == 0) && ($urandom_range(99) >= stall_pct);
            if (res_if.valid && res_if.ready) begin
                if (due_reports.size() == 0) begin
                    report_mismatch("result transaction with no tick waiting for it");
                end else begin
                    want = due_reports.pop_front();
                    reports_checked++;
                    if (want.click_count != 0) latched_seen++;
                    if (want.long_pressed) long_seen++;
                    if (res_if.click_count !== want.click_count)
                        report_mismatch($sformatf("click_count got %0d want %0d",
                                                  res_if.click_count, want.click_count));
                    if (res_if.long_pressed !== want.long_pressed)
                        report_mismatch($sformatf("long_pressed got %b want %b",
                                                  res_if.long_pressed, want.long_pressed));
                    if (res_if.is_pressed !== want.is_pressed)
                        report_mismatch($sformatf("is_pressed got %b want %b",
                                                  res_if.is_pressed, want.is_pressed));
                    if (res_if.phase !== want.phase)
                        report_mismatch($sformatf("phase got %0d want %0d",
                                                  res_if.phase, want.phase));
                end
            end
        end
    end

    // sink hold-off, counted down here once the stimulus arms it
    always @(posedge i_clk) begin
        if (hold_left > 0) hold_left <= hold_left - 1;
    end

    // run limit
    always @(posedge i_clk) begin
        cycles++;
        if (cycles == CYCLE_LIMIT) begin
            $display("[%0t] timeout with %0d reports outstanding", $realtime,
                     due_reports.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // register writes and stimulus helpers
    // ------------------------------------------------------------------------
    task automatic apb_write(t_cfg_idx idx, logic [APB_DW-1:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        // pready is always high, so the access cycle completes at this edge
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            CFG_SHORT_LIMIT: cfg_short_limit = val[LIMIT_W-1:0];
            CFG_LONG_LIMIT:  cfg_long_limit  = val[LIMIT_W-1:0];
            CFG_ACTIVE_LOW:  cfg_active_low  = val[0];
            default:         cfg_connected   = val[0];
        endcase
    endtask

    task automatic set_detector(int short_lim, int long_lim, bit act_low, bit conn);
        apb_write(CFG_SHORT_LIMIT, APB_DW'(short_lim));
        apb_write(CFG_LONG_LIMIT, APB_DW'(long_lim));
        apb_write(CFG_ACTIVE_LOW, APB_DW'(act_low));
        apb_write(CFG_CONNECTED, APB_DW'(conn));
    endtask

    // all ticks taken, all reports in, then a settling wait past the pipeline
    task automatic wait_drained();
        do @(negedge i_clk);
        while (tick_queue.size() != 0 || tick_if.valid || due_reports.size() != 0);
        repeat (DRAIN_WAIT) @(negedge i_clk);
    endtask

    task automatic push_raw(bit pin, bit ack, bit rs);
        t_tick_item t;
        t.pin     = pin;
        t.ack     = ack;
        t.restart = rs;
        tick_queue.push_back(t);
        ticks_queued++;
    endtask

    // press level mapped to the pin through the current polarity, with
    // occasional acknowledges and rare restarts sprinkled in
    task automatic push_level(bit lvl, int reps);
        for (int k = 0; k < reps; k++)
            push_raw(cfg_active_low ? !lvl : lvl, $urandom_range(99) < 8,
                     $urandom_range(99) < 1);
    endtask

    function automatic int cap(int v, int m);
        return (v < m) ? v : m;
    endfunction

    task automatic queue_gestures(int count);
        int target;
        int sel;
        int n_clicks;
        target = ticks_queued + count;
        while (ticks_queued < target) begin
            sel = $urandom_range(99);
            if (sel < 50) begin
                // click burst: short presses, gaps inside the click window,
                // then a quiet stretch that latches the count at small short limits
                n_clicks = $urandom_range(1, 18);
                for (int c = 0; c < n_clicks; c++) begin
                    push_level(1'b1, $urandom_range(1, cap(int'(cfg_long_limit) + 1, 6)));
                    push_level(1'b0, $urandom_range(1, cap(int'(cfg_short_limit) + 1, 6)));
                end
                push_level(1'b0, cap(int'(cfg_short_limit) + 2, 10) + $urandom_range(0, 3));
            end else if (sel < 75) begin
                // hold past the long limit where that limit is small, then let go
                push_level(1'b1, cap(int'(cfg_long_limit) + 2, 30) + $urandom_range(0, 5));
                push_level(1'b0, $urandom_range(1, 4));
            end else begin
                // noise on the pin with free acknowledge and restart bits
                repeat ($urandom_range(1, 10))
                    push_raw(1'($urandom_range(1)), 1'($urandom_range(1)),
                             1'($urandom_range(1)));
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // stimulus sequence
    // ------------------------------------------------------------------------
    initial begin
        int short_set[6];
        int long_set[6];
        bit low_set[6];
        bit conn_set[6];
        int idle_set[6];
        int stall_set[6];

        short_set = '{3, 0, 65535, 5, 2, 8};
        long_set  = '{6, 0, 65535, 10, 4, 1};
        low_set   = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
        conn_set  = '{1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1};
        idle_set  = '{0, 83, 0, 37, 0, 37};
        stall_set = '{0, 0, 83, 37, 0, 37};

        errors          = 0;
        ticks_queued    = 0;
        ticks_taken     = 0;
        reports_checked = 0;
        latched_seen    = 0;
        long_seen       = 0;
        cycles          = 0;
        clear_detector();

        wait (i_rst_n === 1'b1);
        @(negedge i_clk);

        // reset settings: pull-up wiring, so pin low is a press
        push_raw(1'b0, 1'b0, 1'b0);  // pressed while waiting for clear
        push_raw(1'b1, 1'b0, 1'b0);  // release leaves wait for clear
        push_raw(1'b0, 1'b0, 1'b0);
        push_raw(1'b1, 1'b0, 1'b0);  // first click
        push_raw(1'b0, 1'b0, 1'b0);
        push_raw(1'b1, 1'b1, 1'b0);  // second click, acknowledge with nothing latched
        push_raw(1'b1, 1'b0, 1'b1);  // restart from after click
        push_raw(1'b1, 1'b0, 1'b0);
        wait_drained();

        // tight limits, active high: latch, acknowledge, long press, restart
        set_detector(1, 2, 1'b0, 1'b1);
        @(negedge i_clk);
        push_raw(1'b1, 1'b0, 1'b0);
        push_raw(1'b0, 1'b0, 1'b0);
        push_raw(1'b0, 1'b0, 1'b0);
        push_raw(1'b0, 1'b0, 1'b0);  // quiet gap past short limit latches one
        push_raw(1'b0, 1'b1, 1'b0);  // shown, then acknowledged
        push_raw(1'b0, 1'b0, 1'b0);
        push_raw(1'b1, 1'b0, 1'b0);
        push_raw(1'b1, 1'b0, 1'b0);
        push_raw(1'b1, 1'b0, 1'b0);
        push_raw(1'b1, 1'b0, 1'b0);  // held past long limit
        push_raw(1'b1, 1'b1, 1'b0);  // long flag acknowledged while held
        push_raw(1'b1, 1'b0, 1'b0);
        push_raw(1'b0, 1'b0, 1'b0);
        push_raw(1'b1, 1'b0, 1'b1);  // restart while pressed
        push_raw(1'b1, 1'b1, 1'b1);
        push_raw(1'b0, 1'b0, 1'b0);
        wait_drained();

        // random gestures, one setting and one idling mix per phase
        for (int p = 0; p < 6; p++) begin
            set_detector(short_set[p], long_set[p], low_set[p], conn_set[p]);
            @(negedge i_clk);
            idle_pct  = idle_set[p];
            stall_pct = stall_set[p];
            queue_gestures(225);
            // sink holds off while ticks keep coming, so the input backs up
            if (p == 4) hold_left = 300;
            wait_drained();
        end

        $display("run covered %0d ticks and %0d reports over 8 settings", ticks_taken,
                 reports_checked);
        $display("limits 0 to 65535, both polarities, pin disconnected; %0d reports %s %0d %s",
                 latched_seen, "with clicks latched,", long_seen, "with long flag");
        if (errors == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
